// File: src/ebdl_pkg.sv
// Shared types, constants and helper functions of the display link framer.
// No dependencies; every other file of the block imports this package.
package ebdl_pkg;

    // Frame geometry
    localparam int RX_FRAME_BYTES_DEF = 13;
    localparam int TX_FRAME_BYTES     = 12;
    localparam int TX_IDX_W           = $clog2(TX_FRAME_BYTES);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes, taken from paddr[2]
    localparam logic REG_RX_HEADER    = 1'b0;
    localparam logic REG_BATTERY_CODE = 1'b1;

    // Register reset values
    localparam logic [7:0]  RX_HEADER_RST    = 8'h0C;
    localparam logic [7:0]  BATTERY_CODE_RST = 8'd4;
    localparam logic [15:0] WHEEL_TIME_RST   = 16'd2010;

    // Speed clamp and wheel time dividend
    localparam int                 SPEED_W   = 13;
    localparam logic signed [15:0] SPEED_MIN = 16'sd90;
    localparam logic signed [15:0] SPEED_MAX = 16'sd4557;
    localparam int                 DIV_NUM_W = 20;
    localparam logic [DIV_NUM_W-1:0] WHEEL_DIVIDEND = 20'd637992;

    // Fixed status frame bytes
    localparam logic [7:0] TX_SOF   = 8'd65;
    localparam logic [7:0] TX_MODE  = 8'd48;
    localparam logic [7:0] TX_CONST = 8'd2;
    localparam logic [7:0] TX_TAIL  = 8'd13;

    // Result kinds
    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_LEVEL = 1'b1;

    typedef enum logic [1:0] {
        ACT_RX_BYTE = 2'd0,
        ACT_SPEED   = 2'd1,
        ACT_SEND    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         rx_byte;
        logic signed [15:0] speed_rpm10;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [3:0] assist_level;
        logic [8:0] assist_percent;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic rx_step;
        logic div_start;
        logic tx_clr;
        logic tx_load;
        logic rpt_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic rx_report;
        logic div_done;
        logic tx_at_last;
        logic out_free;
    } t_stat;

    // Level times 100 / 5 is level times 20 = 16x + 4x
    function automatic logic [8:0] ebdl_pct(input logic [3:0] lvl);
        ebdl_pct = {1'b0, lvl, 4'b0000} + {3'b000, lvl, 2'b00};
    endfunction

    // Status frame byte at a given position
    function automatic logic [7:0] ebdl_tx_byte(input logic [TX_IDX_W-1:0] idx,
                                                input logic [7:0]  batt,
                                                input logic [15:0] wt);
        logic [7:0] chk;
        chk = batt ^ TX_MODE ^ wt[15:8] ^ wt[7:0] ^ TX_CONST ^ TX_TAIL;
        case (idx)
            4'd0:    ebdl_tx_byte = TX_SOF;
            4'd1:    ebdl_tx_byte = batt;
            4'd2:    ebdl_tx_byte = TX_MODE;
            4'd3:    ebdl_tx_byte = wt[15:8];
            4'd4:    ebdl_tx_byte = wt[7:0];
            4'd6:    ebdl_tx_byte = chk;
            4'd7:    ebdl_tx_byte = TX_CONST;
            4'd8:    ebdl_tx_byte = TX_TAIL;
            default: ebdl_tx_byte = 8'd0;
        endcase
    endfunction

endpackage

// File: src/ebike_display_link_framer.sv
// Top level of the display link framer: configuration port, sequencer, datapath.
// Depends on ebdl_pkg, ebdl_regs, ebdl_ctrl, ebdl_dp (and ebdl_div below it).
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall | o_out_data (t_out_item)
//  config  | to block  | psel penable pwrite pready| paddr, pwdata, prdata
//
// A received byte that ends a frame with a new assist level also issues a level report.
// A speed sample runs the 20-step bit-serial divider.
// A send request puts out one status byte per cycle through the output register,
// slowed while the out channel stalls.
// The output register lets the next request in while the last result waits.
// Reset is synchronous, active low; registers return to their reset values.
module ebike_display_link_framer
    import ebdl_pkg::*;
#(
    parameter int RX_FRAME_BYTES = RX_FRAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic       w_cfg_wr;
    logic [7:0] w_rx_header;
    logic [7:0] w_battery_code;
    t_cmd       w_cmd;
    t_stat      w_stat;

    // Complete a write in the access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    ebdl_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (w_cfg_wr),
        .i_idx          (paddr[2]),
        .i_wdata        (pwdata),
        .o_rdata        (prdata),
        .o_rx_header    (w_rx_header),
        .o_battery_code (w_battery_code)
    );

    ebdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (t_action'(i_in_data.action)),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    ebdl_dp #(
        .RX_FRAME_BYTES (RX_FRAME_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_data      (i_in_data),
        .i_rx_header    (w_rx_header),
        .i_battery_code (w_battery_code),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data)
    );

endmodule

// File: src/ebdl_div.sv
// Restoring divider: fixed wheel time dividend over the clamped speed, one bit a cycle.
// Depends on ebdl_pkg.
module ebdl_div
    import ebdl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SPEED_W-1:0] i_divisor,
    output logic               o_done,
    output logic [15:0]        o_quotient
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy, n_busy;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [SPEED_W-1:0]   r_rem, n_rem;
    logic [SPEED_W-1:0]   r_den, n_den;
    logic [SPEED_W:0]     w_part;
    logic [SPEED_W:0]     w_diff;
    logic                 w_ge;

    // Shift in the next dividend bit and try the subtract
    assign w_part = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_diff = w_part - {1'b0, r_den};
    assign w_ge   = (w_part >= {1'b0, r_den});

    assign o_done     = r_busy && (r_cnt == CNT_W'(DIV_NUM_W - 1));
    assign o_quotient = n_num[15:0];

    // Load on start, then advance one quotient bit a cycle
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = WHEEL_DIVIDEND;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_num = {r_num[DIV_NUM_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[SPEED_W-1:0] : w_part[SPEED_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (o_done) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

`ifndef SYNTHESIS
    // Divisor is at least the speed floor, so the quotient fits 13 bits
    a_quotient_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (n_num < 20'd8192))
        else $error("wheel time quotient out of range");
`endif

endmodule

// File: src/ebdl_ctrl.sv
// Sequencer of the framer: accepts requests, runs divide, report and send phases.
// Depends on ebdl_pkg; drives the datapath through t_cmd and reads t_stat.
module ebdl_ctrl
    import ebdl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_action i_action,
    input  t_stat   i_stat,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REPORT = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_SEND   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_take;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_take     = i_in_valid && (r_state == ST_IDLE);

    // Decode the request and step through the phases
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    case (i_action)
                        ACT_RX_BYTE: begin
                            o_cmd.rx_step = 1'b1;
                            if (i_stat.rx_report) begin
                                n_state = ST_REPORT;
                            end
                        end
                        ACT_SPEED: begin
                            o_cmd.div_start = 1'b1;
                            n_state         = ST_DIV;
                        end
                        ACT_SEND: begin
                            o_cmd.tx_clr = 1'b1;
                            n_state      = ST_SEND;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.rpt_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.tx_load = 1'b1;
                    if (i_stat.tx_at_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // The divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == ST_DIV))
        else $error("divider done outside divide phase");

    // A status frame ends with the sequencer back in idle
    a_send_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.tx_load && i_stat.tx_at_last) |=> (r_state == ST_IDLE))
        else $error("send phase did not end after last byte");
`endif

endmodule

// File: src/ebdl_dp.sv
// Datapath of the framer: receive counter, level store, wheel time, output register.
// Depends on ebdl_pkg and ebdl_div; controlled by ebdl_ctrl via t_cmd / t_stat.
module ebdl_dp
    import ebdl_pkg::*;
#(
    parameter int RX_FRAME_BYTES = RX_FRAME_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  logic [7:0] i_rx_header,
    input  logic [7:0] i_battery_code,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int RXC_W = $clog2(RX_FRAME_BYTES);

    logic [RXC_W-1:0]    r_rx_count, n_rx_count;
    logic [3:0]          r_rx_level, n_rx_level;
    logic [3:0]          r_cur_level, n_cur_level;
    logic [15:0]         r_wheel_time, n_wheel_time;
    logic [TX_IDX_W-1:0] r_tx_idx, n_tx_idx;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic               w_frame_end;
    logic [3:0]         w_level;
    logic [SPEED_W-1:0] w_speed;
    logic               w_div_done;
    logic [15:0]        w_quotient;
    logic               w_out_free;

    // Frame completes on the last byte of a frame already started
    assign w_frame_end = (r_rx_count != '0) && (r_rx_count == RXC_W'(RX_FRAME_BYTES - 1));
    assign w_level     = (r_rx_count == RXC_W'(1)) ? i_in_data.rx_byte[3:0] : r_rx_level;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_stat.rx_report  = w_frame_end && (w_level != r_cur_level);
    assign o_stat.div_done   = w_div_done;
    assign o_stat.tx_at_last = (r_tx_idx == TX_IDX_W'(TX_FRAME_BYTES - 1));
    assign o_stat.out_free   = w_out_free;

    // Clamp the speed sample to the divider range
    always_comb begin
        if (i_in_data.speed_rpm10 < SPEED_MIN) begin
            w_speed = SPEED_W'(SPEED_MIN);
        end else if (i_in_data.speed_rpm10 > SPEED_MAX) begin
            w_speed = SPEED_W'(SPEED_MAX);
        end else begin
            w_speed = i_in_data.speed_rpm10[SPEED_W-1:0];
        end
    end

    ebdl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (w_speed),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Gather received bytes and track the assist level
    always_comb begin
        n_rx_count  = r_rx_count;
        n_rx_level  = r_rx_level;
        n_cur_level = r_cur_level;
        if (i_cmd.rx_step) begin
            if (r_rx_count == '0) begin
                if (i_in_data.rx_byte == i_rx_header) begin
                    n_rx_count = RXC_W'(1);
                end
            end else begin
                if (r_rx_count == RXC_W'(1)) begin
                    n_rx_level = i_in_data.rx_byte[3:0];
                end
                if (w_frame_end) begin
                    n_rx_count  = '0;
                    n_cur_level = w_level;
                end else begin
                    n_rx_count = r_rx_count + 1'b1;
                end
            end
        end
    end

    // Store the new wheel time when the divider finishes
    assign n_wheel_time = w_div_done ? w_quotient : r_wheel_time;

    // Advance the send index and fill the output register
    always_comb begin
        n_tx_idx    = r_tx_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (i_cmd.tx_clr) begin
            n_tx_idx = '0;
        end
        if (i_cmd.tx_load) begin
            n_out.out_kind       = KIND_TX;
            n_out.tx_byte        = ebdl_tx_byte(r_tx_idx, i_battery_code, r_wheel_time);
            n_out.tx_last        = o_stat.tx_at_last;
            n_out.assist_level   = 4'd0;
            n_out.assist_percent = 9'd0;
            n_out_valid          = 1'b1;
            n_tx_idx             = r_tx_idx + 1'b1;
        end else if (i_cmd.rpt_load) begin
            n_out.out_kind       = KIND_LEVEL;
            n_out.tx_byte        = 8'd0;
            n_out.tx_last        = 1'b0;
            n_out.assist_level   = r_cur_level;
            n_out.assist_percent = ebdl_pct(r_cur_level);
            n_out_valid          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count   <= '0;
            r_rx_level   <= 4'd0;
            r_cur_level  <= 4'd0;
            r_wheel_time <= WHEEL_TIME_RST;
            r_tx_idx     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rx_count   <= n_rx_count;
            r_rx_level   <= n_rx_level;
            r_cur_level  <= n_cur_level;
            r_wheel_time <= n_wheel_time;
            r_tx_idx     <= n_tx_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // Never overwrite a result that is still waiting
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tx_load || i_cmd.rpt_load) |-> w_out_free)
        else $error("output register overwritten");

    // The receive counter stays inside one frame
    a_rx_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_count <= RXC_W'(RX_FRAME_BYTES - 1))
        else $error("receive counter past frame length");
`endif

endmodule

// File: src/ebdl_top_placeholder_unused.sv
// Register file of the framer configuration: receive header and battery code.
// Depends on ebdl_pkg; read and written from the top level configuration port.
module ebdl_regs
    import ebdl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  logic               i_idx,
    input  logic [PDATA_W-1:0] i_wdata,
    output logic [PDATA_W-1:0] o_rdata,
    output logic [7:0]         o_rx_header,
    output logic [7:0]         o_battery_code
);

    logic [7:0] r_rx_header, n_rx_header;
    logic [7:0] r_battery_code, n_battery_code;

    // Write the addressed register
    always_comb begin
        n_rx_header    = r_rx_header;
        n_battery_code = r_battery_code;
        if (i_wr) begin
            if (i_idx == REG_RX_HEADER) begin
                n_rx_header = i_wdata[7:0];
            end else begin
                n_battery_code = i_wdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_header    <= RX_HEADER_RST;
            r_battery_code <= BATTERY_CODE_RST;
        end else begin
            r_rx_header    <= n_rx_header;
            r_battery_code <= n_battery_code;
        end
    end

    // Read back the addressed register
    assign o_rdata = (i_idx == REG_RX_HEADER) ? {{(PDATA_W-8){1'b0}}, r_rx_header}
                                              : {{(PDATA_W-8){1'b0}}, r_battery_code};
    assign o_rx_header    = r_rx_header;
    assign o_battery_code = r_battery_code;

endmodule

// File: bench/tb_ebike_display_link_framer.sv
// Self-checking bench for the display link framer: receive frames, speed samples, status frames.
// Depends on ebdl_pkg and ebike_display_link_framer; predicts every result and checks it in order.
module tb_ebike_display_link_framer
    import ebdl_pkg::*;
();

    localparam logic [PADDR_W-1:0] ADDR_RX_HEADER    = {REG_RX_HEADER, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_BATTERY_CODE = {REG_BATTERY_CODE, 2'b00};
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Link model state and configuration
    logic [7:0]  model_hdr;
    logic [7:0]  model_batt;
    int          frame_pos;
    logic [3:0]  frame_level;
    logic [3:0]  shown_level;
    logic [15:0] wheel_period;

    t_out_item link_results_q[$];
    int        error_count;

    // Idle controls of the input and of the stall process
    bit in_jitter;
    bit out_jitter;
    bit hold_request;
    int hold_left;
    int burst_left;

    ebike_display_link_framer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the link model by one accepted request and queue what it emits
    task automatic advance_link_model(input t_in_item req);
        logic [7:0] status [TX_FRAME_BYTES];
        logic [7:0] chk;
        int         speed;
        t_out_item  res;
        case (t_action'(req.action))
            ACT_RX_BYTE: begin
                if (frame_pos == 0) begin
                    if (req.rx_byte == model_hdr)
                        frame_pos = 1;
                end else begin
                    if (frame_pos == 1)
                        frame_level = req.rx_byte[3:0];
                    frame_pos++;
                end
                if (frame_pos >= RX_FRAME_BYTES_DEF) begin
                    frame_pos = 0;
                    if (frame_level != shown_level) begin
                        shown_level = frame_level;
                        res = '0;
                        res.out_kind       = KIND_LEVEL;
                        res.assist_level   = frame_level;
                        res.assist_percent = 9'(int'(frame_level) * 100 / 5);
                        link_results_q.push_back(res);
                    end
                end
            end
            ACT_SPEED: begin
                speed = $signed(req.speed_rpm10);
                if (speed < int'(SPEED_MIN))
                    speed = int'(SPEED_MIN);
                if (speed > int'(SPEED_MAX))
                    speed = int'(SPEED_MAX);
                wheel_period = 16'(int'(WHEEL_DIVIDEND) / speed);
            end
            ACT_SEND: begin
                status[0]  = TX_SOF;
                status[1]  = model_batt;
                status[2]  = TX_MODE;
                status[3]  = wheel_period[15:8];
                status[4]  = wheel_period[7:0];
                status[5]  = 8'd0;
                status[6]  = 8'd0;
                status[7]  = TX_CONST;
                status[8]  = TX_TAIL;
                status[9]  = 8'd0;
                status[10] = 8'd0;
                status[11] = 8'd0;
                chk = 8'd0;
                for (int i = 1; i < TX_FRAME_BYTES; i++)
                    if (i != 6)
                        chk ^= status[i];
                status[6] = chk;
                for (int i = 0; i < TX_FRAME_BYTES; i++) begin
                    res = '0;
                    res.out_kind = KIND_TX;
                    res.tx_byte  = status[i];
                    res.tx_last  = (i == TX_FRAME_BYTES - 1);
                    link_results_q.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_in_item make_req(input t_action act, input logic [7:0] b,
                                          input logic [15:0] spd);
        t_in_item req;
        req.action      = act;
        req.rx_byte     = b;
        req.speed_rpm10 = spd;
        return req;
    endfunction

    // Pick a non-frame request: send, speed sample or unused action
    function automatic t_in_item side_req();
        int pick;
        logic [15:0] spd;
        pick = $urandom_range(0, 9);
        spd = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(60, 4600));
        if (pick < 4)
            return make_req(ACT_SEND, 8'($urandom), 16'($urandom));
        else if (pick < 9)
            return make_req(ACT_SPEED, 8'($urandom), spd);
        return make_req(ACT_NONE, 8'($urandom), 16'($urandom));
    endfunction

    // Offer one request, hold it until accepted, then update the model
    task automatic push_request(input t_in_item req);
        if (in_jitter && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        advance_link_model(req);
    endtask

    // Send a receive frame with the given level nibble, optionally mixed with other requests
    task automatic send_frame(input logic [3:0] lvl, input bit mixed, output int n_req);
        logic [7:0] b;
        n_req = 0;
        for (int i = 0; i < RX_FRAME_BYTES_DEF; i++) begin
            if (mixed && i > 0 && $urandom_range(0, 9) == 0) begin
                push_request(side_req());
                n_req++;
            end
            if (i == 0)
                b = model_hdr;
            else if (i == 1)
                b = {4'($urandom), lvl};
            else
                b = 8'($urandom);
            push_request(make_req(ACT_RX_BYTE, b, 16'($urandom)));
            n_req++;
        end
    endtask

    // Drop valid, drain all results, then let any silent work finish
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (link_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (addr == ADDR_RX_HEADER)
            model_hdr = value;
        else
            model_batt = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_status_at_reset();
        push_request(make_req(ACT_SEND, 8'hFF, 16'hFFFF));
        finish_phase();
    endtask

    task automatic test_speed_clamp();
        in_jitter  = 1'b1;
        out_jitter = 1'b1;
        push_request(make_req(ACT_SPEED, 8'h00, 16'h8000));
        push_request(make_req(ACT_SEND, 8'h00, 16'h0000));
        push_request(make_req(ACT_SPEED, 8'hFF, 16'h7FFF));
        push_request(make_req(ACT_NONE, 8'hFF, 16'hFFFF));
        push_request(make_req(ACT_SEND, 8'hFF, 16'hFFFF));
        finish_phase();
    endtask

    task automatic test_rx_frames();
        int n;
        // Drop a stray byte, then a same-level frame, then a level change
        push_request(make_req(ACT_RX_BYTE, model_hdr ^ 8'h01, 16'h0000));
        send_frame(shown_level, 1'b0, n);
        send_frame(~shown_level, 1'b0, n);
        finish_phase();
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (6)
            push_request(make_req(ACT_SEND, 8'($urandom), 16'($urandom)));
        finish_phase();
    endtask

    task automatic test_random_traffic(input logic [7:0] hdr, input logic [7:0] batt,
                                       input int n_req, input bit jitter);
        int sent;
        int n;
        int pick;
        write_reg(ADDR_RX_HEADER, hdr);
        write_reg(ADDR_BATTERY_CODE, batt);
        in_jitter  = jitter;
        out_jitter = jitter;
        sent = 0;
        while (sent < n_req) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_frame(($urandom_range(0, 1) == 0) ? shown_level : 4'($urandom), 1'b1, n);
                sent += n;
            end else if (pick < 88) begin
                push_request(side_req());
                sent++;
            end else begin
                push_request(make_req(ACT_RX_BYTE, 8'($urandom), 16'($urandom)));
                sent++;
            end
        end
        finish_phase();
    endtask

    // Drive the out-channel stall: long hold on request, else short random bursts
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (out_jitter && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic void compare_field(input string fname, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, fname, want, got);
            error_count++;
        end
    endfunction

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (link_results_q.size() == 0) begin
                $display("%0t mismatch result: expected none actual %h", $time, o_out_data);
                error_count++;
            end else begin
                want = link_results_q.pop_front();
                compare_field("out_kind", 16'(want.out_kind), 16'(o_out_data.out_kind));
                compare_field("tx_byte", 16'(want.tx_byte), 16'(o_out_data.tx_byte));
                compare_field("tx_last", 16'(want.tx_last), 16'(o_out_data.tx_last));
                compare_field("assist_level", 16'(want.assist_level),
                              16'(o_out_data.assist_level));
                compare_field("assist_percent", 16'(want.assist_percent),
                              16'(o_out_data.assist_percent));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        error_count  = 0;
        in_jitter    = 1'b0;
        out_jitter   = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        burst_left   = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        model_hdr    = RX_HEADER_RST;
        model_batt   = BATTERY_CODE_RST;
        frame_pos    = 0;
        frame_level  = 4'd0;
        shown_level  = 4'd0;
        wheel_period = WHEEL_TIME_RST;
        @(posedge i_clk);

        test_status_at_reset();
        test_speed_clamp();
        test_rx_frames();
        test_backpressure();
        test_random_traffic(8'h00, 8'h00, 25, 1'b1);
        test_random_traffic(8'hFF, 8'hFF, 25, 1'b1);
        test_random_traffic(8'($urandom), 8'($urandom), 30, 1'b0);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
